>>> rtl/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

>>> rtl/gconn_pkg.sv
package gconn_pkg;

    localparam int KIND_W      = 2;
    localparam int VIDX_W      = 6;
    localparam int CFG_COUNT_W = 7;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_LSB = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_CLASSIFY = 2'd2,
        KIND_CLEAR    = 2'd3
    } t_kind;

    typedef enum logic {
        REG_VERTEX_COUNT    = 1'b0,
        REG_UNDIRECTED_MODE = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_EDGE_A,
        ST_EDGE_B,
        ST_HEAD,
        ST_HOLD,
        ST_INNER,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_BUILD,
        PH_CLOSE,
        PH_CHECK
    } t_phase;

    typedef enum logic [1:0] {
        EOP_NONE,
        EOP_INC,
        EOP_DEC,
        EOP_ZERO
    } t_edge_op;

    typedef struct packed {
        logic     rd_en;
        t_edge_op op;
    } t_edge_ctrl;

    typedef struct packed {
        logic status;
        logic weakly_connected;
        logic unilaterally_connected;
        logic strongly_connected;
    } t_result;

endpackage

>>> rtl/gconn_if.sv
interface gconn_in_if import gconn_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [VIDX_W-1:0]   src_vertex;
    logic [VIDX_W-1:0]   dst_vertex;

    modport source (output valid, kind, src_vertex, dst_vertex, input ready);
    modport sink (input valid, kind, src_vertex, dst_vertex, output ready);
endinterface

interface gconn_out_if import gconn_pkg::*; ();
    logic valid;
    logic ready;
    logic status;
    logic weakly_connected;
    logic unilaterally_connected;
    logic strongly_connected;

    modport source (
        output valid, status, weakly_connected, unilaterally_connected,
               strongly_connected,
        input  ready
    );
    modport sink (
        input  valid, status, weakly_connected, unilaterally_connected,
               strongly_connected,
        output ready
    );
endinterface

>>> rtl/gconn_edge_store.sv
module gconn_edge_store import gconn_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int COUNT_WIDTH  = 8
) (
    input  logic                              i_clk,
    input  t_edge_ctrl                        i_ctrl,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_rd_row,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_wr_row,
    input  logic [$clog2(MAX_VERTICES)-1:0]   i_col,
    output logic [MAX_VERTICES-1:0]           o_nz_row,
    output logic                              o_nz_col
);

    localparam int RW = MAX_VERTICES * COUNT_WIDTH;

    // One word holds every counter of a matrix row.
    logic [RW-1:0]          r_mem [MAX_VERTICES];
    logic [RW-1:0]          r_rd_data;
    logic [RW-1:0]          wr_data;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] cnt_new;

    assign cnt      = r_rd_data[i_col*COUNT_WIDTH +: COUNT_WIDTH];
    assign o_nz_col = |cnt;

    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            o_nz_row[j] = |r_rd_data[j*COUNT_WIDTH +: COUNT_WIDTH];
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        cnt_new = cnt;
        wr_data = r_rd_data;
        unique case (i_ctrl.op)
            EOP_NONE: begin
                wr_en = 1'b0;
            end
            EOP_INC: begin
                // saturate at the counter maximum
                if (cnt != {COUNT_WIDTH{1'b1}}) begin
                    cnt_new = cnt + COUNT_WIDTH'(1);
                end
                wr_data[i_col*COUNT_WIDTH +: COUNT_WIDTH] = cnt_new;
            end
            EOP_DEC: begin
                // floor at zero
                if (cnt != '0) begin
                    cnt_new = cnt - COUNT_WIDTH'(1);
                end
                wr_data[i_col*COUNT_WIDTH +: COUNT_WIDTH] = cnt_new;
            end
            EOP_ZERO: begin
                wr_data = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_wr_row] <= wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

endmodule

>>> rtl/graph_connectivity_classifier_core.sv
// Edge-multiplicity store with a connectivity classifier. After reset the block sweeps the
// edge memory clear, one row per cycle, and takes no word meanwhile. An add or remove word
// updates one counter, and in undirected mode also the mirrored one when the two vertices
// differ; one that names a vertex outside the active count changes nothing and returns status
// set. A clear word sweeps the memory again. A classify word walks the active n vertices three
// times, using a reach memory with one read and one write port that gives one row per cycle
// within a pass: building adjacency rows from the edge memory, a Warshall closure of the
// directed and symmetrized rows together, and a pairwise check. Each word gives one result
// word, held in an output register so a new word can be taken while the last result waits.
`include "assert_macros.svh"

module graph_connectivity_classifier_core import gconn_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int COUNT_WIDTH  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gconn_in_if.sink              i_in,
    gconn_out_if.source           o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int NW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (NW > CFG_COUNT_W) ? NW : CFG_COUNT_W;
    localparam int MV   = MAX_VERTICES;
    localparam int RRW  = 2 * MAX_VERTICES;

    // configuration
    logic [CFG_COUNT_W-1:0] r_vertex_count;
    logic                   r_undirected;
    logic                   cfg_wr;

    // control
    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [VW-1:0]   r_a, n_a;
    logic [VW-1:0]   r_b, n_b;
    logic [VW-1:0]   r_p1_b;
    logic            r_p1_valid, n_p1_valid;
    logic            r_add, n_add;
    logic            r_mirror, n_mirror;
    logic            r_wipe_item, n_wipe_item;

    // datapath
    logic [MV-1:0]   r_acc_dir, n_acc_dir, acc_dir_v;
    logic [MV-1:0]   r_acc_sym, n_acc_sym, acc_sym_v;
    logic [MV-1:0]   col_mask;
    logic [RRW-1:0]  r_hold, n_hold;
    logic [MV-1:0]   close_dir, close_sym;
    logic            r_weak, n_weak, weak_v;
    logic            r_uni, n_uni, uni_v;
    logic            r_strong, n_strong, strong_v;

    // result
    t_result         r_res, n_res, r_out, fin_res;
    logic            r_out_valid, n_out_valid;
    logic            fin, out_load, slot_free;

    // active count and input decode
    logic [CMPW-1:0] n_ext, nm1;
    logic            a_last, b_last, wipe_last;
    logic            in_fire, oor;
    t_kind           in_kind;

    // edge store port
    t_edge_ctrl      edge_ctrl;
    logic [VW-1:0]   edge_rd_row, edge_wr_row, edge_col;
    logic [MV-1:0]   nz_row;
    logic            nz_col;

    // reach memory: low half directed row, high half symmetrized row
    logic [RRW-1:0]  r_reach_mem [MAX_VERTICES];
    logic [RRW-1:0]  r_reach_rd;
    logic [RRW-1:0]  reach_wd;
    logic [VW-1:0]   reach_ra, reach_wa;
    logic            reach_re, reach_we;

    gconn_edge_store #(
        .MAX_VERTICES (MAX_VERTICES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_edge_store (
        .i_clk    (i_clk),
        .i_ctrl   (edge_ctrl),
        .i_rd_row (edge_rd_row),
        .i_wr_row (edge_wr_row),
        .i_col    (edge_col),
        .o_nz_row (nz_row),
        .o_nz_col (nz_col)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (t_reg_idx'(paddr[REG_IDX_LSB]))
            REG_VERTEX_COUNT:    prdata = APB_DATA_W'(r_vertex_count);
            REG_UNDIRECTED_MODE: prdata = APB_DATA_W'(r_undirected);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CFG_COUNT_W'(1);
            r_undirected   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(paddr[REG_IDX_LSB]))
                REG_VERTEX_COUNT:    r_vertex_count <= pwdata[CFG_COUNT_W-1:0];
                REG_UNDIRECTED_MODE: r_undirected   <= pwdata[0];
            endcase
        end
    end

    // ---------------- decode ----------------
    assign n_ext = (CMPW'(r_vertex_count) > CMPW'(MAX_VERTICES)) ?
                   CMPW'(MAX_VERTICES) : CMPW'(r_vertex_count);
    assign nm1       = n_ext - CMPW'(1);
    assign a_last    = (CMPW'(r_a) == nm1);
    assign b_last    = (CMPW'(r_b) == nm1);
    assign wipe_last = (r_b == VW'(MAX_VERTICES - 1));

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_kind    = t_kind'(i_in.kind);
    assign oor        = (CMPW'(i_in.src_vertex) >= n_ext) ||
                        (CMPW'(i_in.dst_vertex) >= n_ext);

    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            col_mask[j] = (CMPW'(j) < n_ext);
        end
    end

    assign slot_free = !r_out_valid || o_out.ready;

    // ---------------- stage-1 datapath ----------------
    always_comb begin
        acc_dir_v = r_acc_dir;
        acc_sym_v = r_acc_sym;
        if (r_phase == PH_BUILD && r_p1_valid) begin
            // column entry of the outer vertex in this row, then the row itself
            acc_sym_v[r_p1_b] = acc_sym_v[r_p1_b] | nz_col;
            if (r_p1_b == r_a) begin
                acc_dir_v = nz_row & col_mask;
                acc_sym_v = acc_sym_v | (nz_row & col_mask);
            end
        end
    end

    always_comb begin
        close_dir = r_reach_rd[MV-1:0];
        close_sym = r_reach_rd[RRW-1:MV];
        if (r_reach_rd[r_a]) begin
            close_dir = close_dir | r_hold[MV-1:0];
        end
        if (r_reach_rd[MV + r_a]) begin
            close_sym = close_sym | r_hold[RRW-1:MV];
        end
    end

    always_comb begin
        weak_v   = r_weak;
        uni_v    = r_uni;
        strong_v = r_strong;
        if (r_phase == PH_CHECK && r_p1_valid) begin
            if (!r_hold[r_p1_b]) begin
                strong_v = 1'b0;
            end
            if (r_p1_b != r_a && !r_hold[r_p1_b] && !r_reach_rd[r_a]) begin
                uni_v = 1'b0;
            end
            if (r_a == '0 && r_p1_b != '0 && !r_hold[MV + r_p1_b]) begin
                weak_v = 1'b0;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_a         = r_a;
        n_b         = r_b;
        n_p1_valid  = r_p1_valid;
        n_add       = r_add;
        n_mirror    = r_mirror;
        n_wipe_item = r_wipe_item;
        n_acc_dir   = acc_dir_v;
        n_acc_sym   = acc_sym_v;
        n_hold      = r_hold;
        n_weak      = weak_v;
        n_uni       = uni_v;
        n_strong    = strong_v;
        n_res       = r_res;
        fin         = 1'b0;
        fin_res     = '0;
        out_load    = 1'b0;

        edge_ctrl.rd_en = 1'b0;
        edge_ctrl.op    = EOP_NONE;
        edge_rd_row     = r_b;
        edge_wr_row     = r_b;
        edge_col        = r_a;

        reach_re = 1'b0;
        reach_ra = r_a;
        reach_we = 1'b0;
        reach_wa = r_a;
        reach_wd = {acc_sym_v, acc_dir_v};

        if (r_phase == PH_CLOSE && r_p1_valid) begin
            reach_we = 1'b1;
            reach_wa = r_p1_b;
            reach_wd = {close_sym, close_dir};
        end

        unique case (r_state)
            ST_WIPE: begin
                edge_ctrl.op = EOP_ZERO;
                edge_wr_row  = r_b;
                if (wipe_last) begin
                    n_wipe_item = 1'b0;
                    if (r_wipe_item) begin
                        fin = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_b = r_b + VW'(1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (in_kind) inside
                        KIND_ADD, KIND_REMOVE: begin
                            if (oor) begin
                                fin            = 1'b1;
                                fin_res.status = 1'b1;
                            end else begin
                                edge_ctrl.rd_en = 1'b1;
                                edge_rd_row     = VW'(i_in.src_vertex);
                                n_a             = VW'(i_in.src_vertex);
                                n_b             = VW'(i_in.dst_vertex);
                                n_add           = (in_kind == KIND_ADD);
                                n_mirror        = r_undirected &&
                                                  (i_in.src_vertex != i_in.dst_vertex);
                                n_state         = ST_EDGE_A;
                            end
                        end
                        KIND_CLASSIFY: begin
                            if (n_ext == '0) begin
                                fin = 1'b1;
                                fin_res.weakly_connected       = 1'b1;
                                fin_res.unilaterally_connected = 1'b1;
                                fin_res.strongly_connected     = 1'b1;
                            end else begin
                                n_phase   = PH_BUILD;
                                n_a       = '0;
                                n_b       = '0;
                                n_acc_dir = '0;
                                n_acc_sym = '0;
                                n_weak    = 1'b1;
                                n_uni     = 1'b1;
                                n_strong  = 1'b1;
                                n_state   = ST_INNER;
                            end
                        end
                        KIND_CLEAR: begin
                            n_b         = '0;
                            n_wipe_item = 1'b1;
                            n_state     = ST_WIPE;
                        end
                    endcase
                end
            end
            ST_EDGE_A: begin
                edge_ctrl.op = r_add ? EOP_INC : EOP_DEC;
                edge_wr_row  = r_a;
                edge_col     = r_b;
                if (r_mirror) begin
                    edge_ctrl.rd_en = 1'b1;
                    edge_rd_row     = r_b;
                    n_state         = ST_EDGE_B;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_EDGE_B: begin
                edge_ctrl.op = r_add ? EOP_INC : EOP_DEC;
                edge_wr_row  = r_b;
                edge_col     = r_a;
                fin          = 1'b1;
            end
            ST_HEAD: begin
                reach_re = 1'b1;
                reach_ra = r_a;
                n_state  = ST_HOLD;
            end
            ST_HOLD: begin
                n_hold  = r_reach_rd;
                n_b     = '0;
                n_state = ST_INNER;
            end
            ST_INNER: begin
                if (r_phase == PH_BUILD) begin
                    edge_ctrl.rd_en = 1'b1;
                    edge_rd_row     = r_b;
                end else begin
                    reach_re = 1'b1;
                    reach_ra = r_b;
                end
                n_p1_valid = 1'b1;
                if (b_last) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_b = r_b + VW'(1);
                end
            end
            ST_DRAIN: begin
                n_p1_valid = 1'b0;
                if (r_phase == PH_BUILD) begin
                    // row complete: store it and start the next one empty
                    reach_we  = 1'b1;
                    reach_wa  = r_a;
                    reach_wd  = {acc_sym_v, acc_dir_v};
                    n_acc_dir = '0;
                    n_acc_sym = '0;
                end
                if (a_last) begin
                    n_a = '0;
                    unique case (r_phase)
                        PH_BUILD: begin
                            n_phase = PH_CLOSE;
                            n_state = ST_HEAD;
                        end
                        PH_CLOSE: begin
                            n_phase = PH_CHECK;
                            n_state = ST_HEAD;
                        end
                        PH_CHECK: begin
                            fin = 1'b1;
                            fin_res.weakly_connected       = weak_v;
                            fin_res.unilaterally_connected = uni_v;
                            fin_res.strongly_connected     = strong_v;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end else begin
                    n_a = r_a + VW'(1);
                    if (r_phase == PH_BUILD) begin
                        n_b     = '0;
                        n_state = ST_INNER;
                    end else begin
                        n_state = ST_HEAD;
                    end
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or hold it until the slot frees
        if (fin) begin
            n_res = fin_res;
            if (slot_free) begin
                out_load = 1'b1;
                n_state  = ST_IDLE;
            end else begin
                n_state  = ST_EMIT;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_phase     <= PH_BUILD;
            r_a         <= '0;
            r_b         <= '0;
            r_p1_valid  <= 1'b0;
            r_wipe_item <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_a         <= n_a;
            r_b         <= n_b;
            r_p1_valid  <= n_p1_valid;
            r_wipe_item <= n_wipe_item;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_b    <= r_b;
        r_add     <= n_add;
        r_mirror  <= n_mirror;
        r_acc_dir <= n_acc_dir;
        r_acc_sym <= n_acc_sym;
        r_hold    <= n_hold;
        r_weak    <= n_weak;
        r_uni     <= n_uni;
        r_strong  <= n_strong;
        r_res     <= n_res;
        if (out_load) begin
            r_out <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (reach_we) begin
            r_reach_mem[reach_wa] <= reach_wd;
        end
        if (reach_re) begin
            r_reach_rd <= r_reach_mem[reach_ra];
        end
    end

    assign o_out.valid                  = r_out_valid;
    assign o_out.status                 = r_out.status;
    assign o_out.weakly_connected       = r_out.weakly_connected;
    assign o_out.unilaterally_connected = r_out.unilaterally_connected;
    assign o_out.strongly_connected     = r_out.strongly_connected;

    // ---------------- assertions ----------------
    `ASSERT_NEVER(a_reach_rw_same_row, i_clk, i_rst_n,
        reach_we && reach_re && reach_wa == reach_ra,
        "reach memory read and write hit the same row")
    `ASSERT_NEVER(a_edge_rw_same_row, i_clk, i_rst_n,
        edge_ctrl.op != EOP_NONE && edge_ctrl.rd_en && edge_wr_row == edge_rd_row,
        "edge memory read and write hit the same row")
    `ASSERT_CLK(a_stage_after_issue, i_clk, i_rst_n,
        r_p1_valid |-> $past(r_state == ST_INNER),
        "stage-1 data without a read issued the cycle before")
    `ASSERT_CLK(a_no_result_from_reset_wipe, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state) != ST_WIPE || $past(r_wipe_item),
        "reset sweep produced a result word")

endmodule
